// ----- rtl/aqs_pkg.sv -----
// ----------------------------------------------------------------------------
// aqs_pkg
// Shared constants, codes and controller/datapath link types for the
// array store with quicksort unit.
// ----------------------------------------------------------------------------
package aqs_pkg;

	// Default configuration
	localparam int CAPACITY_DEF  = 64;
	localparam int KEY_WIDTH_DEF = 32;

	// Fixed port widths
	localparam int ACTION_W = 2;
	localparam int KEY_IO_W = 32;
	localparam int INDEX_W  = 6;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 6;
	localparam int COUNT_W  = 7;

	// Request actions
	localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_SORT   = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

	// Commands from controller to datapath
	typedef struct packed {
		logic take;       // request accepted
		logic rd_pivot;   // read key at hi, load scan pointers
		logic ld_pivot;   // capture pivot key
		logic rd_scan;    // read keys at j and store pointer
		logic wr_store;   // write key j into store slot
		logic wr_j;       // write old store key into slot j
		logic adv_j;      // step scan pointer
		logic adv_st;     // step store pointer
		logic rd_fin;     // read key at store pointer
		logic wr_fin_st;  // write pivot into store slot
		logic wr_fin_hi;  // write old store key into slot hi
		logic push_l;     // push left subrange
		logic push_r;     // push right subrange
		logic pop;        // pop a range off the stack
		logic ld_range;   // load popped range
		logic finish;     // sort complete, emit result
	} aqs_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic sort_start;  // sort request with two or more keys
		logic key_le;      // scanned key orders at or below pivot
		logic j_last;      // scan pointer at last element before pivot
		logic push_l;      // left subrange holds two or more keys
		logic push_r;      // right subrange holds two or more keys
		logic stack_empty; // no pending ranges
	} aqs_sts_t;

endpackage

// ----- rtl/array_store_with_quicksort_unit.sv -----
// ----------------------------------------------------------------------------
// array_store_with_quicksort_unit
// Fixed-capacity key store with append, indexed read and in-place ascending
// sort (Lomuto partition, explicit range stack).
//
//   Channel   Signals                               Handshake
//   request   action, key_in, read_index            start & !busy
//   result    status, key_out, position, count      done, one cycle
//   config    cfg_wdata (compare_signed)            cfg_we
//
// Append, read, unused codes and a sort of fewer than two keys answer in the
// cycle after the request, and a new request can be taken every cycle while
// no sort holds busy. A sort holds busy while it partitions ranges and walks
// the range stack, paced by the key memory's single write port and its
// registered reads; done comes in the cycle busy drops.
// Reset clears the key count, the stack pointer and compare_signed; no
// clearing pass. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module array_store_with_quicksort_unit #(
	parameter int CAPACITY  = aqs_pkg::CAPACITY_DEF,
	parameter int KEY_WIDTH = aqs_pkg::KEY_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_wdata,
	input  logic                         start,
	output logic                         busy,
	input  logic [aqs_pkg::ACTION_W-1:0] action,
	input  logic [aqs_pkg::KEY_IO_W-1:0] key_in,
	input  logic [aqs_pkg::INDEX_W-1:0]  read_index,
	output logic                         done,
	output logic [aqs_pkg::STATUS_W-1:0] status,
	output logic [aqs_pkg::KEY_IO_W-1:0] key_out,
	output logic [aqs_pkg::POS_W-1:0]    position,
	output logic [aqs_pkg::COUNT_W-1:0]  count
);
	import aqs_pkg::*;

	aqs_cmd_t cmd;
	aqs_sts_t sts;

	// Sequencer
	aqs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Storage and arithmetic
	aqs_datapath #(
		.CAPACITY  (CAPACITY),
		.KEY_WIDTH (KEY_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.action     (action),
		.key_in     (key_in),
		.read_index (read_index),
		.cmd        (cmd),
		.sts        (sts),
		.done       (done),
		.status     (status),
		.key_out    (key_out),
		.position   (position),
		.count      (count)
	);

	// No result strobe while a sort is running
	a_no_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !done)
		else $error("result strobe during sort");

	// Append, read and unused requests answer in the next cycle
	a_quick_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && action != ACT_SORT) |=> (done && !busy))
		else $error("missing result for single-cycle request");

	// A sort request either answers at once or starts the sequencer
	a_sort_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && action == ACT_SORT) |=> (busy != done))
		else $error("sort request neither answered nor started");

	// Failed requests return no key
	a_err_key_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (key_out == '0 && position == '0))
		else $error("key or position on failed request");

endmodule

// ----- rtl/aqs_datapath.sv -----
// ----------------------------------------------------------------------------
// aqs_datapath
// Key memory, range stack, scan pointers, comparator and result registers.
// ----------------------------------------------------------------------------
module aqs_datapath #(
	parameter int CAPACITY  = aqs_pkg::CAPACITY_DEF,
	parameter int KEY_WIDTH = aqs_pkg::KEY_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_wdata,
	input  logic [aqs_pkg::ACTION_W-1:0] action,
	input  logic [aqs_pkg::KEY_IO_W-1:0] key_in,
	input  logic [aqs_pkg::INDEX_W-1:0]  read_index,
	input  aqs_pkg::aqs_cmd_t            cmd,
	output aqs_pkg::aqs_sts_t            sts,
	output logic                         done,
	output logic [aqs_pkg::STATUS_W-1:0] status,
	output logic [aqs_pkg::KEY_IO_W-1:0] key_out,
	output logic [aqs_pkg::POS_W-1:0]    position,
	output logic [aqs_pkg::COUNT_W-1:0]  count
);
	import aqs_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > COUNT_W) ? CW : COUNT_W;
	localparam int KW = KEY_WIDTH;
	localparam logic [KW-1:0] KEY_ONE  = KW'(1);
	localparam logic [KW-1:0] SIGN_BIT = KEY_ONE << (KW - 1);

	// Storage
	logic [KW-1:0]     key_mem [CAPACITY];
	logic [2*AW-1:0]   stk_mem [CAPACITY];

	// Registers
	logic [CW-1:0]     count_q;
	logic              signed_q;
	logic [AW-1:0]     sp_q;
	logic [AW-1:0]     lo_q, hi_q, j_q, st_q;
	logic [KW-1:0]     pivot_q;
	logic [KW-1:0]     rd_a_q, rd_b_q;
	logic [2*AW-1:0]   stk_rd_q;
	logic              done_q;
	logic              read_ok_q;
	logic [STATUS_W-1:0] status_q;
	logic [POS_W-1:0]  pos_q;

	// Decoded request
	logic              full;
	logic [XW-1:0]     count_x;
	logic [XW-1:0]     idx_x;
	logic              idx_ok;
	logic              is_append, is_read, is_sort;

	assign full      = (count_q == CW'(CAPACITY));
	assign count_x   = XW'(count_q);
	assign idx_x     = XW'(read_index);
	assign idx_ok    = (idx_x < count_x);
	assign is_append = (action == ACT_APPEND);
	assign is_read   = (action == ACT_READ);
	assign is_sort   = (action == ACT_SORT);

	// Compare in order-key form: flip the sign bit for signed keys
	logic [KW-1:0] ord_a, ord_p;
	assign ord_a = rd_a_q ^ (signed_q ? SIGN_BIT : '0);
	assign ord_p = pivot_q ^ (signed_q ? SIGN_BIT : '0);

	// Status to controller
	assign sts.sort_start  = is_sort && (count_q >= CW'(2));
	assign sts.key_le      = (ord_a <= ord_p);
	assign sts.j_last      = ((AW+1)'(j_q) + (AW+1)'(1)) == (AW+1)'(hi_q);
	assign sts.push_l      = (AW+1)'(st_q) > ((AW+1)'(lo_q) + (AW+1)'(1));
	assign sts.push_r      = ((AW+1)'(st_q) + (AW+1)'(1)) < (AW+1)'(hi_q);
	assign sts.stack_empty = (sp_q == '0);

	// Key memory port select
	logic          key_we;
	logic [AW-1:0] key_wa;
	logic [KW-1:0] key_wd;
	logic          rd_a_en, rd_b_en;
	logic [AW-1:0] rd_a_addr;

	always_comb begin
		key_we = 1'b0;
		key_wa = '0;
		key_wd = '0;
		if (cmd.take && is_append && !full) begin
			key_we = 1'b1;
			key_wa = count_q[AW-1:0];
			key_wd = KW'(key_in);
		end else if (cmd.wr_store) begin
			key_we = 1'b1;
			key_wa = st_q;
			key_wd = rd_a_q;
		end else if (cmd.wr_j) begin
			key_we = 1'b1;
			key_wa = j_q;
			key_wd = rd_b_q;
		end else if (cmd.wr_fin_st) begin
			key_we = 1'b1;
			key_wa = st_q;
			key_wd = pivot_q;
		end else if (cmd.wr_fin_hi) begin
			key_we = 1'b1;
			key_wa = hi_q;
			key_wd = rd_b_q;
		end
	end

	assign rd_a_en   = (cmd.take && is_read) || cmd.rd_pivot || cmd.rd_scan;
	assign rd_b_en   = cmd.rd_scan || cmd.rd_fin;
	assign rd_a_addr = cmd.rd_pivot ? hi_q : (cmd.rd_scan ? j_q : idx_x[AW-1:0]);

	// Key memory: one write, two registered reads
	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[key_wa] <= key_wd;
		end
		if (rd_a_en) begin
			rd_a_q <= key_mem[rd_a_addr];
		end
		if (rd_b_en) begin
			rd_b_q <= key_mem[st_q];
		end
	end

	// Range stack memory: push one range a cycle, registered pop read
	logic            stk_we;
	logic [2*AW-1:0] stk_wd;
	logic [AW-1:0]   sp_dec;

	assign stk_we = cmd.push_l || cmd.push_r;
	assign stk_wd = cmd.push_l ? {lo_q, st_q - AW'(1)} : {st_q + AW'(1), hi_q};
	assign sp_dec = sp_q - AW'(1);

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[sp_q] <= stk_wd;
		end
		if (cmd.pop) begin
			stk_rd_q <= stk_mem[sp_dec];
		end
	end

	// Stack pointer, count and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q     <= '0;
			count_q  <= '0;
			signed_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				signed_q <= cfg_wdata;
			end
			if (cmd.take && is_append && !full) begin
				count_q <= count_q + CW'(1);
			end
			if (stk_we) begin
				sp_q <= sp_q + AW'(1);
			end else if (cmd.pop) begin
				sp_q <= sp_dec;
			end
		end
	end

	// Range bounds, scan pointers and pivot
	always_ff @(posedge clk) begin
		if (cmd.take && sts.sort_start) begin
			lo_q <= '0;
			hi_q <= AW'(count_q - CW'(1));
		end else if (cmd.ld_range) begin
			lo_q <= stk_rd_q[2*AW-1:AW];
			hi_q <= stk_rd_q[AW-1:0];
		end
		if (cmd.rd_pivot) begin
			j_q  <= lo_q;
			st_q <= lo_q;
		end else begin
			if (cmd.adv_j) begin
				j_q <= j_q + AW'(1);
			end
			if (cmd.adv_st) begin
				st_q <= st_q + AW'(1);
			end
		end
		if (cmd.ld_pivot) begin
			pivot_q <= rd_a_q;
		end
	end

	// Result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q    <= 1'b0;
			read_ok_q <= 1'b0;
		end else begin
			done_q    <= (cmd.take && !sts.sort_start) || cmd.finish;
			read_ok_q <= cmd.take && is_read && idx_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			status_q <= ST_OK;
			pos_q    <= '0;
			if (is_append) begin
				if (full) begin
					status_q <= ST_FULL;
				end else begin
					pos_q <= count_x[POS_W-1:0];
				end
			end else if (is_read && !idx_ok) begin
				status_q <= ST_RANGE;
			end
		end else if (cmd.finish) begin
			status_q <= ST_OK;
			pos_q    <= '0;
		end
	end

	// Drive result ports
	assign done     = done_q;
	assign status   = status_q;
	assign key_out  = read_ok_q ? KEY_IO_W'(rd_a_q) : '0;
	assign position = pos_q;
	assign count    = count_x[COUNT_W-1:0];

endmodule

// ----- rtl/aqs_ctrl.sv -----
// ----------------------------------------------------------------------------
// aqs_ctrl
// Sequencer for requests and for the Lomuto partition / range stack walk.
// ----------------------------------------------------------------------------
module aqs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  aqs_pkg::aqs_sts_t sts,
	output aqs_pkg::aqs_cmd_t cmd,
	output logic              busy
);
	import aqs_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PIV_RD,
		S_PIV_LD,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_SCAN_WR,
		S_FIN_RD,
		S_FIN_WR1,
		S_FIN_WR2,
		S_PUSH_R,
		S_POP,
		S_POP_LD
	} state_t;

	state_t state_q, state_d;
	logic   busy_q;

	// Decode commands and next state
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.take = start;
				if (start && sts.sort_start) begin
					state_d = S_PIV_RD;
				end
			end
			S_PIV_RD: begin
				cmd.rd_pivot = 1'b1;
				state_d      = S_PIV_LD;
			end
			S_PIV_LD: begin
				cmd.ld_pivot = 1'b1;
				state_d      = S_SCAN_RD;
			end
			S_SCAN_RD: begin
				cmd.rd_scan = 1'b1;
				state_d     = S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				if (sts.key_le) begin
					cmd.wr_store = 1'b1;
					state_d      = S_SCAN_WR;
				end else begin
					cmd.adv_j = 1'b1;
					state_d   = sts.j_last ? S_FIN_RD : S_SCAN_RD;
				end
			end
			S_SCAN_WR: begin
				cmd.wr_j   = 1'b1;
				cmd.adv_j  = 1'b1;
				cmd.adv_st = 1'b1;
				state_d    = sts.j_last ? S_FIN_RD : S_SCAN_RD;
			end
			S_FIN_RD: begin
				cmd.rd_fin = 1'b1;
				state_d    = S_FIN_WR1;
			end
			S_FIN_WR1: begin
				cmd.wr_fin_st = 1'b1;
				state_d       = S_FIN_WR2;
			end
			S_FIN_WR2: begin
				cmd.wr_fin_hi = 1'b1;
				cmd.push_l    = sts.push_l;
				state_d       = sts.push_r ? S_PUSH_R : S_POP;
			end
			S_PUSH_R: begin
				cmd.push_r = 1'b1;
				state_d    = S_POP;
			end
			S_POP: begin
				if (sts.stack_empty) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end else begin
					cmd.pop = 1'b1;
					state_d = S_POP_LD;
				end
			end
			S_POP_LD: begin
				cmd.ld_range = 1'b1;
				state_d      = S_PIV_RD;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Hold state and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != S_IDLE);
		end
	end

	assign busy = busy_q;

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the array store with quicksort unit. A scripted
// opening covers the empty store, single-key sort, unused action code, the
// key extremes and signed versus unsigned ordering. Random traffic then fills
// the store to capacity and beyond, mixing appends, reads and sorts across
// both compare modes and several sender idle rates. Every result is checked
// field by field against a typed-in reply or a behavioral store model in the bench.
// ----------------------------------------------------------------------------
module tb_top;
	import aqs_pkg::*;

	// Action code the unit takes but ignores
	localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

	localparam int STORE_DEPTH  = CAPACITY_DEF;
	localparam int RANDOM_ITEMS = 1550;
	localparam int SEGMENTS     = 6;
	localparam int SORT_BUDGET  = 45;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [KEY_IO_W-1:0] key;
		logic [POS_W-1:0]    pos;
		logic [COUNT_W-1:0]  cnt;
	} store_reply_t;

	typedef struct {
		int                  cfg;     // compare mode to set first, -1 keeps it
		logic [ACTION_W-1:0] act;
		logic [KEY_IO_W-1:0] key;
		logic [INDEX_W-1:0]  idx;
		bit                  pinned;  // reply typed in below
		store_reply_t        reply;
	} script_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic                cfg_wdata;
	logic                start;
	logic                busy;
	logic [ACTION_W-1:0] action;
	logic [KEY_IO_W-1:0] key_in;
	logic [INDEX_W-1:0]  read_index;
	logic                done;
	logic [STATUS_W-1:0] status;
	logic [KEY_IO_W-1:0] key_out;
	logic [POS_W-1:0]    position;
	logic [COUNT_W-1:0]  count;

	// Store model
	logic [KEY_IO_W-1:0] model_keys [STORE_DEPTH];
	int                  model_count;
	bit                  model_signed;

	store_reply_t        replies_due [$];
	script_row_t         script [$];
	bit                  pin_valid;
	store_reply_t        pin_reply;
	store_reply_t        due_reply;
	store_reply_t        seen_reply;
	store_reply_t        model_reply;
	int                  idle_pct;
	int                  sorts_left;
	int                  errors;
	int                  n_checked;
	int                  n_appends;
	int                  n_full;
	int                  n_reads;
	int                  n_range;
	int                  n_sorts;

	array_store_with_quicksort_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.key_in     (key_in),
		.read_index (read_index),
		.done       (done),
		.status     (status),
		.key_out    (key_out),
		.position   (position),
		.count      (count)
	);

	always #5 clk = ~clk;

	// Flip the sign bit so a signed compare becomes an unsigned one
	function automatic logic [KEY_IO_W-1:0] order_of(logic [KEY_IO_W-1:0] k);
		return {k[KEY_IO_W-1] ^ model_signed, k[KEY_IO_W-2:0]};
	endfunction

	// Lomuto quicksort over the stored keys with an explicit range stack
	function automatic void sort_model_keys();
		int                  lo_stk [STORE_DEPTH];
		int                  hi_stk [STORE_DEPTH];
		int                  depth;
		int                  lo;
		int                  hi;
		int                  p;
		logic [KEY_IO_W-1:0] pivot_ord;
		logic [KEY_IO_W-1:0] t;
		if (model_count < 2)
			return;
		lo_stk[0] = 0;
		hi_stk[0] = model_count - 1;
		depth = 1;
		while (depth > 0) begin
			depth--;
			lo = lo_stk[depth];
			hi = hi_stk[depth];
			pivot_ord = order_of(model_keys[hi]);
			p = lo;
			for (int j = lo; j < hi; j++) begin
				if (order_of(model_keys[j]) <= pivot_ord) begin
					t = model_keys[p];
					model_keys[p] = model_keys[j];
					model_keys[j] = t;
					p++;
				end
			end
			t = model_keys[p];
			model_keys[p] = model_keys[hi];
			model_keys[hi] = t;
			if (p > lo + 1) begin
				lo_stk[depth] = lo;
				hi_stk[depth] = p - 1;
				depth++;
			end
			if (p + 1 < hi) begin
				lo_stk[depth] = p + 1;
				hi_stk[depth] = hi;
				depth++;
			end
		end
	endfunction

	// Apply one request to the model and return the reply it gives
	function automatic store_reply_t step_store_model(logic [ACTION_W-1:0] act,
			logic [KEY_IO_W-1:0] key, logic [INDEX_W-1:0] idx);
		store_reply_t r;
		r = '0;
		r.status = ST_OK;
		case (act)
			ACT_APPEND: begin
				if (model_count >= STORE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					model_keys[model_count] = key;
					r.pos = POS_W'(model_count);
					model_count++;
				end
			end
			ACT_SORT: begin
				sort_model_keys();
			end
			ACT_READ: begin
				if (int'(idx) >= model_count)
					r.status = ST_RANGE;
				else
					r.key = model_keys[idx];
			end
			default: begin
			end
		endcase
		r.cnt = COUNT_W'(model_count);
		return r;
	endfunction

	task automatic check_reply(store_reply_t exp_r, store_reply_t got_r);
		if (got_r.status !== exp_r.status) begin
			$display("%0t: status mismatch: expected %0d, got %0d",
				$time, exp_r.status, got_r.status);
			errors++;
		end
		if (got_r.key !== exp_r.key) begin
			$display("%0t: key_out mismatch: expected %h, got %h",
				$time, exp_r.key, got_r.key);
			errors++;
		end
		if (got_r.pos !== exp_r.pos) begin
			$display("%0t: position mismatch: expected %0d, got %0d",
				$time, exp_r.pos, got_r.pos);
			errors++;
		end
		if (got_r.cnt !== exp_r.cnt) begin
			$display("%0t: count mismatch: expected %0d, got %0d",
				$time, exp_r.cnt, got_r.cnt);
			errors++;
		end
	endtask

	// Check results, predict accepted requests, track the compare mode
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				seen_reply = '{status, key_out, position, count};
				if (replies_due.size() == 0) begin
					$display("%0t: unexpected result: got %h", $time, seen_reply);
					errors++;
				end else begin
					due_reply = replies_due.pop_front();
					check_reply(due_reply, seen_reply);
					n_checked++;
				end
			end
			if (start && !busy) begin
				model_reply = step_store_model(action, key_in, read_index);
				replies_due.push_back(pin_valid ? pin_reply : model_reply);
				case (action)
					ACT_APPEND: begin
						n_appends++;
						if (model_reply.status == ST_FULL)
							n_full++;
					end
					ACT_READ: begin
						n_reads++;
						if (model_reply.status == ST_RANGE)
							n_range++;
					end
					ACT_SORT: n_sorts++;
					default: begin
					end
				endcase
			end
			if (cfg_we)
				model_signed = cfg_wdata;
		end
	end

	// Drive one request; enter and leave at a falling edge
	task automatic issue(logic [ACTION_W-1:0] act, logic [KEY_IO_W-1:0] key,
			logic [INDEX_W-1:0] idx, bit pinned, store_reply_t reply);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		pin_valid = pinned;
		pin_reply = reply;
		start <= 1'b1;
		action <= act;
		key_in <= key;
		read_index <= idx;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Drain all outstanding requests, then write the compare mode
	task automatic set_compare_mode(bit mode);
		start <= 1'b0;
		while (replies_due.size() != 0 || busy)
			@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= mode;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic add_row(int cfg, logic [ACTION_W-1:0] act, logic [KEY_IO_W-1:0] key,
			logic [INDEX_W-1:0] idx, bit pinned, logic [STATUS_W-1:0] st,
			logic [KEY_IO_W-1:0] k, logic [POS_W-1:0] pos, logic [COUNT_W-1:0] cnt);
		script_row_t row;
		row.cfg = cfg;
		row.act = act;
		row.key = key;
		row.idx = idx;
		row.pinned = pinned;
		row.reply = '{st, k, pos, cnt};
		script.push_back(row);
	endtask

	// Favor extremes and duplicates so sorts meet equal and sign-split keys
	function automatic logic [KEY_IO_W-1:0] pick_key();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return 32'h8000_0000;
			3: return 32'h7fff_ffff;
			4: return KEY_IO_W'($urandom_range(0, 3));
			5: return 32'hffff_fffc | KEY_IO_W'($urandom_range(0, 3));
			default: return $urandom;
		endcase
	endfunction

	task automatic random_request();
		int                  r;
		logic [ACTION_W-1:0] act;
		logic [INDEX_W-1:0]  idx;
		r = $urandom_range(0, 99);
		if (model_count < STORE_DEPTH)
			act = (r < 30) ? ACT_APPEND : (r < 34) ? ACT_SORT : (r < 38) ? ACT_NONE : ACT_READ;
		else
			act = (r < 12) ? ACT_APPEND : (r < 14) ? ACT_SORT : (r < 18) ? ACT_NONE : ACT_READ;
		// Cap sorts: a sort of a full store is costly
		if (act == ACT_SORT) begin
			if (sorts_left == 0)
				act = ACT_READ;
			else
				sorts_left--;
		end
		if (model_count > 0 && $urandom_range(0, 4) != 0)
			idx = INDEX_W'($urandom_range(0, model_count - 1));
		else
			idx = INDEX_W'($urandom_range(0, 63));
		issue(act, pick_key(), idx, 1'b0, '0);
	endtask

	// Scripted opening; rows with pinned set carry their reply
	task automatic build_script();
		add_row( 0, ACT_READ,   '0,            6'd0,  1, ST_RANGE, '0, 6'd0, 7'd0);
		add_row(-1, ACT_SORT,   '0,            6'd0,  1, ST_OK,    '0, 6'd0, 7'd0);
		add_row(-1, ACT_NONE,   '1,            6'd63, 1, ST_OK,    '0, 6'd0, 7'd0);
		add_row(-1, ACT_APPEND, '1,            6'd0,  1, ST_OK,    '0, 6'd0, 7'd1);
		add_row(-1, ACT_SORT,   '0,            6'd0,  1, ST_OK,    '0, 6'd0, 7'd1);
		add_row(-1, ACT_READ,   '0,            6'd0,  1, ST_OK,    '1, 6'd0, 7'd1);
		add_row(-1, ACT_APPEND, 32'h8000_0000, 6'd0,  1, ST_OK,    '0, 6'd1, 7'd2);
		add_row(-1, ACT_APPEND, 32'h7fff_ffff, 6'd0,  1, ST_OK,    '0, 6'd2, 7'd3);
		add_row(-1, ACT_APPEND, '0,            6'd0,  1, ST_OK,    '0, 6'd3, 7'd4);
		add_row(-1, ACT_APPEND, 32'd1,         6'd0,  1, ST_OK,    '0, 6'd4, 7'd5);
		add_row(-1, ACT_APPEND, 32'h8000_0000, 6'd0,  1, ST_OK,    '0, 6'd5, 7'd6);
		add_row(-1, ACT_READ,   '0,            6'd63, 1, ST_RANGE, '0, 6'd0, 7'd6);
		add_row(-1, ACT_READ,   '0,            6'd6,  1, ST_RANGE, '0, 6'd0, 7'd6);
		add_row(-1, ACT_SORT,   '0,            6'd0,  1, ST_OK,    '0, 6'd0, 7'd6);
		for (int i = 0; i < 6; i++)
			add_row(-1, ACT_READ, '0, INDEX_W'(i), 0, ST_OK, '0, 6'd0, 7'd0);
		add_row( 1, ACT_SORT,   '0,            6'd0,  1, ST_OK,    '0, 6'd0, 7'd6);
		add_row(-1, ACT_READ,   '0,            6'd0,  0, ST_OK,    '0, 6'd0, 7'd0);
		add_row(-1, ACT_READ,   '0,            6'd5,  0, ST_OK,    '0, 6'd0, 7'd0);
		add_row(-1, ACT_NONE,   '0,            6'd0,  1, ST_OK,    '0, 6'd0, 7'd6);
		add_row(-1, ACT_READ,   '0,            6'd2,  0, ST_OK,    '0, 6'd0, 7'd0);
	endtask

	// Main sequence: reset, scripted opening, random segments, drain
	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		action = ACT_APPEND;
		key_in = '0;
		read_index = '0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		pin_valid = 1'b0;
		pin_reply = '0;
		model_count = 0;
		model_signed = 1'b0;
		idle_pct = 0;
		sorts_left = SORT_BUDGET;
		errors = 0;
		n_checked = 0;
		n_appends = 0;
		n_full = 0;
		n_reads = 0;
		n_range = 0;
		n_sorts = 0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		build_script();
		foreach (script[i]) begin
			if (script[i].cfg >= 0)
				set_compare_mode(script[i].cfg[0]);
			issue(script[i].act, script[i].key, script[i].idx, script[i].pinned,
				script[i].reply);
		end

		// Sender idle 37%, then 68%, then none; alternate the compare mode
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			idle_pct = (seg < 2) ? 37 : (seg < 4) ? 68 : 0;
			set_compare_mode(seg % 2 == 0);
			for (int n = 0; n < (RANDOM_ITEMS + SEGMENTS - 1) / SEGMENTS; n++)
				random_request();
		end

		start <= 1'b0;
		while (replies_due.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);

		$display("Checked %0d results: %0d appends (%0d on a full store), %0d reads (%0d out of range), %0d sorts",
			n_checked, n_appends, n_full, n_reads, n_range, n_sorts);
		$display("Both compare modes used on a growing and a full store, sender idle 37, 68 and 0 pct");
		if (errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

	// Hard stop well past the slowest legal run
	initial begin
		#40_000_000;
		$display("tb_top failed");
		$finish;
	end

endmodule
